// File: design/dchs_pkg.sv
// Shared types and constants for the DTLS ClientHello scanner.
`default_nettype none

package dchs_pkg;

    // Message format constants
    localparam logic [15:0] LEGACY_VERSION    = 16'hfefd;
    localparam logic [15:0] RANDOM_BYTES      = 16'd32;
    localparam logic [15:0] MIN_SUITES_LEN    = 16'd2;
    localparam logic [1:0]  EXT_HDR_LAST      = 2'd3;   // index of last of 4 header bytes
    localparam int          MAX_MESSAGE_BYTES = 65535;
    localparam logic [15:0] MAX_SCAN_POS      = 16'(MAX_MESSAGE_BYTES);
    localparam logic [15:0] POS_SATURATED     = 16'hffff;

    // Record kinds
    localparam logic [2:0] KIND_RANDOM   = 3'd0;
    localparam logic [2:0] KIND_SUITES   = 3'd1;
    localparam logic [2:0] KIND_COOKIE   = 3'd2;
    localparam logic [2:0] KIND_VERSIONS = 3'd3;
    localparam logic [2:0] KIND_GROUPS   = 3'd4;
    localparam logic [2:0] KIND_SHARES   = 3'd5;
    localparam logic [2:0] KIND_FINAL    = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_COOKIE   = 2'd0;
    localparam logic [1:0] CFG_VERSIONS = 2'd1;
    localparam logic [1:0] CFG_GROUPS   = 2'd2;
    localparam logic [1:0] CFG_SHARES   = 2'd3;

    // Reset values of the extension type registers
    localparam logic [15:0] COOKIE_TYPE_RST   = 16'd44;
    localparam logic [15:0] VERSIONS_TYPE_RST = 16'd43;
    localparam logic [15:0] GROUPS_TYPE_RST   = 16'd10;
    localparam logic [15:0] SHARES_TYPE_RST   = 16'd51;

    // Output queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Output beat layout
    localparam int OUT_TDATA_W = 40;

    typedef struct packed {
        logic [15:0] cookie;
        logic [15:0] versions;
        logic [15:0] groups;
        logic [15:0] shares;
    } ext_types_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] offset;
        logic [15:0] length;
        logic        accepted;
        logic        end_of_run;
    } rec_t;

    // Up to two records per byte: a field record, then the verdict
    typedef struct packed {
        logic field_valid;
        rec_t field_rec;
        logic final_valid;
        rec_t final_rec;
    } rec_pair_t;

endpackage

`default_nettype wire

// File: design/dchs_parser.sv
// Byte-level ClientHello parse state and record generation.
`default_nettype none

module dchs_parser
    import dchs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_en,
    input  wire logic [7:0] byte_data,
    input  wire logic       byte_last,
    input  wire ext_types_t ext_types,
    output rec_pair_t       recs
);

    typedef enum logic [3:0] {
        PH_VER_HI, PH_VER_LO, PH_RANDOM, PH_SID_LEN, PH_SID, PH_CK_LEN,
        PH_SL_HI, PH_SL_LO, PH_SUITES, PH_CMP_LEN, PH_CMP, PH_EL_HI,
        PH_EL_LO, PH_EXT_HDR, PH_EXT_BODY, PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        V_UNDECIDED, V_ACCEPTED, V_REJECTED
    } verdict_t;

    phase_t      phase_reg, phase_next;
    verdict_t    verdict_reg, verdict_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] skip_reg, skip_next;
    logic [15:0] scratch_reg, scratch_next;
    logic [15:0] ext_type_reg, ext_type_next;
    logic [15:0] fstart_reg, fstart_next;

    logic [15:0] pos_inc;
    logic [15:0] skip_dec;
    logic [15:0] byte_pair;
    logic [15:0] ext_len;
    logic        ext_hit;
    logic [2:0]  ext_kind;
    logic        scan_en;

    assign pos_inc   = pos_reg + 16'd1;
    assign skip_dec  = skip_reg - 16'd1;
    assign byte_pair = {scratch_reg[7:0], byte_data};
    assign ext_len   = {scratch_reg[15:8], byte_data};
    assign scan_en   = (pos_reg < MAX_SCAN_POS);

    // Extension type match, first register wins
    always_comb
    begin
        ext_hit  = 1'b1;
        ext_kind = KIND_COOKIE;
        if (ext_type_reg == ext_types.cookie)
            ext_kind = KIND_COOKIE;
        else if (ext_type_reg == ext_types.versions)
            ext_kind = KIND_VERSIONS;
        else if (ext_type_reg == ext_types.groups)
            ext_kind = KIND_GROUPS;
        else if (ext_type_reg == ext_types.shares)
            ext_kind = KIND_SHARES;
        else
            ext_hit = 1'b0;
    end

    // Next state and records for the current byte
    always_comb
    begin
        phase_next    = phase_reg;
        verdict_next  = verdict_reg;
        skip_next     = skip_reg;
        scratch_next  = scratch_reg;
        ext_type_next = ext_type_reg;
        fstart_next   = fstart_reg;
        pos_next      = (pos_reg != POS_SATURATED) ? pos_inc : pos_reg;

        recs.field_valid          = 1'b0;
        recs.field_rec.kind       = KIND_RANDOM;
        recs.field_rec.offset     = fstart_reg;
        recs.field_rec.length     = scratch_reg;
        recs.field_rec.accepted   = 1'b0;
        recs.field_rec.end_of_run = 1'b0;

        recs.final_valid          = byte_last;
        recs.final_rec.kind       = KIND_FINAL;
        recs.final_rec.offset     = 16'd0;
        recs.final_rec.length     = 16'd0;
        recs.final_rec.end_of_run = 1'b1;

        if (scan_en)
        begin
            case (phase_reg)
                PH_VER_HI:
                begin
                    scratch_next = {8'd0, byte_data};
                    phase_next   = PH_VER_LO;
                end
                PH_VER_LO:
                begin
                    if (byte_pair == LEGACY_VERSION)
                    begin
                        skip_next  = RANDOM_BYTES;
                        phase_next = PH_RANDOM;
                    end
                    else
                    begin
                        verdict_next = V_REJECTED;
                        phase_next   = PH_DONE;
                    end
                end
                PH_RANDOM:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                    begin
                        recs.field_valid      = 1'b1;
                        recs.field_rec.kind   = KIND_RANDOM;
                        recs.field_rec.offset = pos_inc - RANDOM_BYTES;
                        recs.field_rec.length = RANDOM_BYTES;
                        phase_next            = PH_SID_LEN;
                    end
                end
                PH_SID_LEN:
                begin
                    if (byte_data == 8'd0)
                        phase_next = PH_CK_LEN;
                    else
                    begin
                        skip_next  = {8'd0, byte_data};
                        phase_next = PH_SID;
                    end
                end
                PH_SID:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                        phase_next = PH_CK_LEN;
                end
                PH_CK_LEN:
                begin
                    // legacy cookie must be empty
                    if (byte_data != 8'd0)
                    begin
                        verdict_next = V_REJECTED;
                        phase_next   = PH_DONE;
                    end
                    else
                        phase_next = PH_SL_HI;
                end
                PH_SL_HI:
                begin
                    scratch_next = {8'd0, byte_data};
                    phase_next   = PH_SL_LO;
                end
                PH_SL_LO:
                begin
                    if ((byte_pair < MIN_SUITES_LEN) || byte_pair[0])
                    begin
                        verdict_next = V_REJECTED;
                        phase_next   = PH_DONE;
                    end
                    else
                    begin
                        scratch_next = byte_pair;
                        skip_next    = byte_pair;
                        fstart_next  = pos_inc;
                        phase_next   = PH_SUITES;
                    end
                end
                PH_SUITES:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                    begin
                        recs.field_valid    = 1'b1;
                        recs.field_rec.kind = KIND_SUITES;
                        verdict_next        = V_ACCEPTED;
                        phase_next          = PH_CMP_LEN;
                    end
                end
                PH_CMP_LEN:
                begin
                    if (byte_data == 8'd0)
                        phase_next = PH_EL_HI;
                    else
                    begin
                        skip_next  = {8'd0, byte_data};
                        phase_next = PH_CMP;
                    end
                end
                PH_CMP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                        phase_next = PH_EL_HI;
                end
                PH_EL_HI:
                    phase_next = PH_EL_LO;
                PH_EL_LO:
                begin
                    skip_next  = 16'd0;
                    phase_next = PH_EXT_HDR;
                end
                PH_EXT_HDR:
                begin
                    // skip counts header bytes 0..3: type hi, type lo, len hi, len lo
                    skip_next = skip_reg + 16'd1;
                    case (skip_reg[1:0])
                        2'd0:    ext_type_next = {byte_data, 8'd0};
                        2'd1:    ext_type_next = {ext_type_reg[15:8], byte_data};
                        2'd2:    scratch_next  = {byte_data, 8'd0};
                        default: scratch_next  = ext_len;
                    endcase
                    if (skip_reg[1:0] == EXT_HDR_LAST)
                    begin
                        if (ext_len == 16'd0)
                        begin
                            // empty extension: report now
                            recs.field_valid      = ext_hit;
                            recs.field_rec.kind   = ext_kind;
                            recs.field_rec.offset = pos_inc;
                            recs.field_rec.length = 16'd0;
                            skip_next             = 16'd0;
                        end
                        else
                        begin
                            skip_next   = ext_len;
                            fstart_next = pos_inc;
                            phase_next  = PH_EXT_BODY;
                        end
                    end
                end
                PH_EXT_BODY:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                    begin
                        recs.field_valid    = ext_hit;
                        recs.field_rec.kind = ext_kind;
                        phase_next          = PH_EXT_HDR;
                    end
                end
                default:
                begin
                    // PH_DONE: hold until the last byte
                end
            endcase
        end

        // Verdict includes the effect of this byte
        recs.final_rec.accepted = (verdict_next == V_ACCEPTED);

        // Rearm for the next message
        if (byte_last)
        begin
            phase_next    = PH_VER_HI;
            verdict_next  = V_UNDECIDED;
            pos_next      = 16'd0;
            skip_next     = 16'd0;
            scratch_next  = 16'd0;
            ext_type_next = 16'd0;
            fstart_next   = 16'd0;
        end
    end

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_VER_HI;
            verdict_reg  <= V_UNDECIDED;
            pos_reg      <= 16'd0;
            skip_reg     <= 16'd0;
            scratch_reg  <= 16'd0;
            ext_type_reg <= 16'd0;
            fstart_reg   <= 16'd0;
        end
        else if (byte_en)
        begin
            phase_reg    <= phase_next;
            verdict_reg  <= verdict_next;
            pos_reg      <= pos_next;
            skip_reg     <= skip_next;
            scratch_reg  <= scratch_next;
            ext_type_reg <= ext_type_next;
            fstart_reg   <= fstart_next;
        end
    end

endmodule

`default_nettype wire

// File: design/dchs_out_queue.sv
// Small record queue: takes up to two records per cycle, sends one beat per cycle while out_ready is high.
`default_nettype none

module dchs_out_queue
    import dchs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_en,
    input  wire rec_pair_t push_recs,
    output logic           room,
    output logic           out_valid,
    input  wire logic      out_ready,
    output rec_t           out_rec
);

    rec_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    logic              push_a;
    logic              push_b;
    rec_t              rec_a;
    rec_t              rec_b;
    logic [QPTR_W-1:0] wr_ptr_inc;
    logic              pop;
    logic [QCNT_W-1:0] push_cnt;

    // Room for a worst-case byte (two records) before any pop
    assign room      = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_rec   = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Compact the pair: first present record goes to the write pointer
    always_comb
    begin
        push_a   = 1'b0;
        push_b   = 1'b0;
        rec_a    = push_recs.field_rec;
        rec_b    = push_recs.final_rec;
        push_cnt = '0;
        if (push_en)
        begin
            if (push_recs.field_valid)
            begin
                push_a   = 1'b1;
                push_b   = push_recs.final_valid;
                push_cnt = push_recs.final_valid ? QCNT_W'(2) : QCNT_W'(1);
            end
            else if (push_recs.final_valid)
            begin
                push_a   = 1'b1;
                rec_a    = push_recs.final_rec;
                push_cnt = QCNT_W'(1);
            end
        end
        wr_ptr_inc  = wr_ptr_reg + QPTR_W'(1);
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_cnt);
        count_next  = count_reg + push_cnt - QCNT_W'(pop);
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push_a)
            entry_reg[wr_ptr_reg] <= rec_a;
        if (push_b)
            entry_reg[wr_ptr_inc] <= rec_b;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
        end
    end

endmodule

`default_nettype wire

// File: design/dtls_client_hello_scanner.sv
// Top level of the DTLS ClientHello scanner: input stage, config registers, parser, queue.
//
// The scanner takes one ClientHello body byte per beat and reports the random, the
// cipher-suites list and each complete extension of four programmable types as
// offset/length beats, then a verdict beat (tlast high) after the last byte. Each
// byte waits in the input register, where the parser updates its counters and
// compares, and its records land in a four-entry output queue. The input takes one
// byte per cycle while the queue holds at most two records; a byte that ends a field
// and the message at once yields two beats. The user must write the extension type
// codes through the cfg port only while idle; the block itself does not enforce this.
`default_nettype none

module dtls_client_hello_scanner
    import dchs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,   // [7:0] data_byte
    input  wire logic                   s_axis_tlast,   // last_byte

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [15:0] field_offset,
                                                        // [31:16] field_length,
                                                        // [32] accepted, [39:33] zero
    output logic [2:0]                  m_axis_tuser,   // [2:0] record_kind
    output logic                        m_axis_tlast,   // end_of_run

    input  wire logic                   cfg_wr_en,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [15:0]            cfg_data
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    ext_types_t ext_types_reg;

    logic       room;
    logic       advance;
    rec_pair_t  recs;
    rec_t       out_rec;

    assign advance       = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || room;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tvalid && s_axis_tready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Extension type registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_types_reg.cookie   <= COOKIE_TYPE_RST;
            ext_types_reg.versions <= VERSIONS_TYPE_RST;
            ext_types_reg.groups   <= GROUPS_TYPE_RST;
            ext_types_reg.shares   <= SHARES_TYPE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_COOKIE:   ext_types_reg.cookie   <= cfg_data;
                CFG_VERSIONS: ext_types_reg.versions <= cfg_data;
                CFG_GROUPS:   ext_types_reg.groups   <= cfg_data;
                CFG_SHARES:   ext_types_reg.shares   <= cfg_data;
                default:      ext_types_reg.cookie   <= ext_types_reg.cookie;
            endcase
        end
    end

    dchs_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (advance),
        .byte_data (in_byte_reg),
        .byte_last (in_last_reg),
        .ext_types (ext_types_reg),
        .recs      (recs)
    );

    dchs_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (advance),
        .push_recs (recs),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_rec   (out_rec)
    );

    // Output beat packing
    assign m_axis_tdata = {7'd0, out_rec.accepted, out_rec.length, out_rec.offset};
    assign m_axis_tuser = out_rec.kind;
    assign m_axis_tlast = out_rec.end_of_run;

endmodule

`default_nettype wire

// File: design/dchs_checker.sv
// Port-level assertions for the DTLS ClientHello scanner, bound to the top level.
`default_nettype none

module dchs_checker
    import dchs_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [2:0]             m_axis_tuser,
    input wire logic                   m_axis_tlast
);

    // Only the verdict beat closes a message
    a_last_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_FINAL)))
        else $error("tlast does not match verdict kind");

    // Verdict beat carries no offset or length
    a_final_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("verdict beat has nonzero offset/length");

    // Field beats never claim acceptance
    a_field_not_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !m_axis_tdata[32])
        else $error("field beat has accepted set");

    // Random is always 32 bytes
    a_random_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_RANDOM)) |->
            (m_axis_tdata[31:16] == RANDOM_BYTES))
        else $error("random record length is not 32");

    // Stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("output beat changed while stalled");

endmodule

bind dtls_client_hello_scanner dchs_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: tb/dtls_client_hello_scanner_tb.sv
// Self-checking testbench for the DTLS ClientHello scanner: byte stream in, record beats checked.
`default_nettype none

module dtls_client_hello_scanner_tb;
    import dchs_pkg::*;

    localparam int IDLE_PCT       = 32;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 16;

    // Scan phases and verdict of the local predictor
    typedef enum logic [3:0] {
        SC_VER_HI, SC_VER_LO, SC_RANDOM, SC_SID_LEN, SC_SID, SC_CK_LEN,
        SC_SL_HI, SC_SL_LO, SC_SUITES, SC_CMP_LEN, SC_CMP, SC_EL_HI,
        SC_EL_LO, SC_EXT_HDR, SC_EXT_BODY, SC_DONE
    } scan_phase_e;

    typedef enum logic [1:0] {
        VD_UNDECIDED, VD_ACCEPTED, VD_REJECTED
    } verdict_e;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_beat_t;

    logic                   clk;
    logic                   rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;

    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [2:0]             m_axis_tuser;
    logic                   m_axis_tlast;

    logic                   cfg_wr_en = 1'b0;
    logic [1:0]             cfg_index = CFG_COOKIE;
    logic [15:0]            cfg_data = '0;

    // Stimulus and expectation stores
    byte_beat_t  byte_q[$];
    logic [7:0]  hello_buf[$];
    rec_t        expected_records[$];
    byte_beat_t  cur_beat;
    rec_t        exp_rec;

    logic [15:0] ext_code [4];
    logic        hold_in = 1'b0;
    logic        no_idle = 1'b0;
    logic        in_taken = 1'b0;
    int          stim_bytes = 0;
    int          mismatches = 0;
    int          stall_cnt = 0;

    // Predictor state
    scan_phase_e scan_ph;
    verdict_e    verdict;
    logic [15:0] msg_pos;
    logic [15:0] skip_cnt;
    logic [15:0] len_acc;
    logic [15:0] hdr_type;
    logic [15:0] body_start;

    dtls_client_hello_scanner dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------- predictor ----------------

    task automatic clear_scan();
        scan_ph    = SC_VER_HI;
        verdict    = VD_UNDECIDED;
        msg_pos    = '0;
        skip_cnt   = '0;
        len_acc    = '0;
        hdr_type   = '0;
        body_start = '0;
    endtask

    task automatic push_rec(input logic [2:0] kind, input logic [15:0] off,
                            input logic [15:0] len, input logic acc, input logic eor);
        rec_t r;
        r.kind       = kind;
        r.offset     = off;
        r.length     = len;
        r.accepted   = acc;
        r.end_of_run = eor;
        expected_records.push_back(r);
    endtask

    // First matching register wins: cookie, versions, groups, shares
    task automatic report_ext(input logic [15:0] off, input logic [15:0] len);
        if (hdr_type == ext_code[CFG_COOKIE])
            push_rec(KIND_COOKIE, off, len, 1'b0, 1'b0);
        else if (hdr_type == ext_code[CFG_VERSIONS])
            push_rec(KIND_VERSIONS, off, len, 1'b0, 1'b0);
        else if (hdr_type == ext_code[CFG_GROUPS])
            push_rec(KIND_GROUPS, off, len, 1'b0, 1'b0);
        else if (hdr_type == ext_code[CFG_SHARES])
            push_rec(KIND_SHARES, off, len, 1'b0, 1'b0);
    endtask

    task automatic predict_scan(input logic [7:0] b, input logic last);
        logic [15:0] nxt;
        logic [15:0] l;
        nxt = msg_pos + 16'd1;
        // bytes past the scan window are only counted
        if (msg_pos != MAX_SCAN_POS)
        begin
            case (scan_ph)
                SC_VER_HI:
                begin
                    len_acc = {8'h00, b};
                    scan_ph = SC_VER_LO;
                end
                SC_VER_LO:
                begin
                    if ({len_acc[7:0], b} == LEGACY_VERSION)
                    begin
                        skip_cnt = RANDOM_BYTES;
                        scan_ph  = SC_RANDOM;
                    end
                    else
                    begin
                        verdict = VD_REJECTED;
                        scan_ph = SC_DONE;
                    end
                end
                SC_RANDOM:
                begin
                    skip_cnt = skip_cnt - 16'd1;
                    if (skip_cnt == 16'd0)
                    begin
                        push_rec(KIND_RANDOM, nxt - RANDOM_BYTES, RANDOM_BYTES, 1'b0, 1'b0);
                        scan_ph = SC_SID_LEN;
                    end
                end
                SC_SID_LEN:
                begin
                    if (b == 8'd0)
                        scan_ph = SC_CK_LEN;
                    else
                    begin
                        skip_cnt = {8'h00, b};
                        scan_ph  = SC_SID;
                    end
                end
                SC_SID:
                begin
                    skip_cnt = skip_cnt - 16'd1;
                    if (skip_cnt == 16'd0)
                        scan_ph = SC_CK_LEN;
                end
                SC_CK_LEN:
                begin
                    if (b != 8'd0)
                    begin
                        verdict = VD_REJECTED;
                        scan_ph = SC_DONE;
                    end
                    else
                        scan_ph = SC_SL_HI;
                end
                SC_SL_HI:
                begin
                    len_acc = {8'h00, b};
                    scan_ph = SC_SL_LO;
                end
                SC_SL_LO:
                begin
                    l = {len_acc[7:0], b};
                    if (l < MIN_SUITES_LEN || l[0])
                    begin
                        verdict = VD_REJECTED;
                        scan_ph = SC_DONE;
                    end
                    else
                    begin
                        len_acc    = l;
                        skip_cnt   = l;
                        body_start = nxt;
                        scan_ph    = SC_SUITES;
                    end
                end
                SC_SUITES:
                begin
                    skip_cnt = skip_cnt - 16'd1;
                    if (skip_cnt == 16'd0)
                    begin
                        push_rec(KIND_SUITES, body_start, len_acc, 1'b0, 1'b0);
                        verdict = VD_ACCEPTED;
                        scan_ph = SC_CMP_LEN;
                    end
                end
                SC_CMP_LEN:
                begin
                    if (b == 8'd0)
                        scan_ph = SC_EL_HI;
                    else
                    begin
                        skip_cnt = {8'h00, b};
                        scan_ph  = SC_CMP;
                    end
                end
                SC_CMP:
                begin
                    skip_cnt = skip_cnt - 16'd1;
                    if (skip_cnt == 16'd0)
                        scan_ph = SC_EL_HI;
                end
                SC_EL_HI:
                    scan_ph = SC_EL_LO;
                SC_EL_LO:
                begin
                    skip_cnt = '0;
                    scan_ph  = SC_EXT_HDR;
                end
                SC_EXT_HDR:
                begin
                    // header byte index: type hi, type lo, length hi, length lo
                    case (skip_cnt[1:0])
                        2'd0:    hdr_type = {b, 8'h00};
                        2'd1:    hdr_type[7:0] = b;
                        2'd2:    len_acc = {b, 8'h00};
                        default: len_acc[7:0] = b;
                    endcase
                    skip_cnt = skip_cnt + 16'd1;
                    if (skip_cnt > 16'(EXT_HDR_LAST))
                    begin
                        if (len_acc == 16'd0)
                        begin
                            report_ext(nxt, 16'd0);
                            skip_cnt = '0;
                        end
                        else
                        begin
                            skip_cnt   = len_acc;
                            body_start = nxt;
                            scan_ph    = SC_EXT_BODY;
                        end
                    end
                end
                SC_EXT_BODY:
                begin
                    skip_cnt = skip_cnt - 16'd1;
                    if (skip_cnt == 16'd0)
                    begin
                        report_ext(body_start, len_acc);
                        scan_ph = SC_EXT_HDR;
                    end
                end
                default: ;
            endcase
        end
        if (msg_pos != POS_SATURATED)
            msg_pos = nxt;
        if (last)
        begin
            push_rec(KIND_FINAL, 16'd0, 16'd0, verdict == VD_ACCEPTED, 1'b1);
            clear_scan();
        end
    endtask

    // ---------------- message building ----------------

    task automatic put_hdr(input logic [15:0] ver, input int sid_len, input int ck_len,
                           input int suites_len, input int cmp_len);
        int i;
        hello_buf.push_back(ver[15:8]);
        hello_buf.push_back(ver[7:0]);
        for (i = 0; i < 32; i++)
            hello_buf.push_back(8'($urandom));
        hello_buf.push_back(8'(sid_len));
        for (i = 0; i < sid_len; i++)
            hello_buf.push_back(8'($urandom));
        hello_buf.push_back(8'(ck_len));
        for (i = 0; i < ck_len; i++)
            hello_buf.push_back(8'($urandom));
        hello_buf.push_back(8'(suites_len >> 8));
        hello_buf.push_back(8'(suites_len));
        for (i = 0; i < suites_len; i++)
            hello_buf.push_back(8'($urandom));
        hello_buf.push_back(8'(cmp_len));
        for (i = 0; i < cmp_len; i++)
            hello_buf.push_back(8'($urandom));
        // declared extensions length, not used by the block
        hello_buf.push_back(8'($urandom));
        hello_buf.push_back(8'($urandom));
    endtask

    task automatic put_ext(input logic [15:0] code, input int len);
        int i;
        hello_buf.push_back(code[15:8]);
        hello_buf.push_back(code[7:0]);
        hello_buf.push_back(8'(len >> 8));
        hello_buf.push_back(8'(len));
        for (i = 0; i < len; i++)
            hello_buf.push_back(8'($urandom));
    endtask

    // Queue the first keep bytes of the buffer (all of it if keep is out of range), last flag on the final one
    task automatic send_buf(input int keep);
        int i;
        byte_beat_t bb;
        if (keep < 1 || keep > hello_buf.size())
            keep = hello_buf.size();
        for (i = 0; i < keep; i++)
        begin
            bb.data = hello_buf[i];
            bb.last = (i == keep - 1);
            byte_q.push_back(bb);
        end
        stim_bytes += keep;
        hello_buf.delete();
    endtask

    task automatic gen_random_message();
        int mode;
        int n_ext;
        int i;
        int n;
        logic [15:0] code;
        logic [15:0] ver;
        byte_beat_t bb;
        mode = $urandom_range(99);
        if (mode < 70)
        begin
            // well-formed hello with random content, sometimes cut short
            put_hdr(LEGACY_VERSION,
                    ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(4),
                    0, 2 * $urandom_range(1, 4), $urandom_range(2));
            n_ext = $urandom_range(4);
            for (i = 0; i < n_ext; i++)
            begin
                code = ($urandom_range(3) != 0) ? ext_code[$urandom_range(3)]
                                                : 16'($urandom);
                put_ext(code, $urandom_range(6));
            end
            send_buf(($urandom_range(3) == 0) ? $urandom_range(1, hello_buf.size())
                                              : hello_buf.size());
        end
        else if (mode < 88)
        begin
            // broken hello
            case ($urandom_range(3))
                0:
                begin
                    ver = 16'($urandom);
                    if (ver == LEGACY_VERSION)
                        ver[0] = ~ver[0];
                    put_hdr(ver, 0, 0, 2, 0);
                end
                1:       put_hdr(LEGACY_VERSION, $urandom_range(2), $urandom_range(1, 255), 2, 0);
                2:       put_hdr(LEGACY_VERSION, 0, 0, 2 * $urandom_range(3) + 1, 0);
                default: put_hdr(LEGACY_VERSION, 0, 0, 0, 0);
            endcase
            send_buf(($urandom_range(1) == 0) ? $urandom_range(1, hello_buf.size())
                                              : hello_buf.size());
        end
        else
        begin
            // noise, with stray last flags
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
            begin
                bb.data = 8'($urandom);
                bb.last = ($urandom_range(3) == 0) || (i == n - 1);
                byte_q.push_back(bb);
            end
            stim_bytes += n;
        end
    endtask

    // ---------------- sequencing helpers ----------------

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        ext_code[idx] = val;
    endtask

    task automatic set_codes(input logic [15:0] ck, input logic [15:0] vs,
                             input logic [15:0] gr, input logic [15:0] sh);
        write_reg(CFG_COOKIE, ck);
        write_reg(CFG_VERSIONS, vs);
        write_reg(CFG_GROUPS, gr);
        write_reg(CFG_SHARES, sh);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Wait for the block to go idle with nothing outstanding
    task automatic settle();
        while (byte_q.size() != 0 || s_axis_tvalid || expected_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int budget);
        int start;
        int idx;
        start = stim_bytes;
        idx = 0;
        while (stim_bytes - start < budget)
        begin
            gen_random_message();
            // now and then hold the sender until all records are out
            if (idx % 4 == 0)
            begin
                hold_in = 1'b1;
                @(posedge clk);
                while (s_axis_tvalid || expected_records.size() != 0)
                    @(posedge clk);
                hold_in = 1'b0;
            end
            idx++;
        end
    endtask

    // ---------------- driver ----------------

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_taken)
            begin
                in_taken = 1'b0;
                if (byte_q.size() != 0 && !hold_in &&
                    (no_idle || $urandom_range(99) >= IDLE_PCT))
                begin
                    cur_beat = byte_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= cur_beat.data;
                    s_axis_tlast  <= cur_beat.last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ---------------- monitor, checker, watchdog ----------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_scan(s_axis_tdata, s_axis_tlast);
                in_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_records.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected record: kind %0d off %0d len %0d acc %0b eor %0b",
                                 m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                                 m_axis_tdata[32], m_axis_tlast);
                end
                else
                begin
                    exp_rec = expected_records.pop_front();
                    if (m_axis_tuser !== exp_rec.kind ||
                        m_axis_tdata[15:0] !== exp_rec.offset ||
                        m_axis_tdata[31:16] !== exp_rec.length ||
                        m_axis_tdata[32] !== exp_rec.accepted ||
                        m_axis_tdata[39:33] !== 7'd0 ||
                        m_axis_tlast !== exp_rec.end_of_run)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("record mismatch: exp kind %0d off %0d len %0d acc %0b eor %0b",
                                     exp_rec.kind, exp_rec.offset, exp_rec.length,
                                     exp_rec.accepted, exp_rec.end_of_run);
                            $display("  got kind %0d off %0d len %0d acc %0b eor %0b pad %0h",
                                     m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                                     m_axis_tdata[32], m_axis_tlast, m_axis_tdata[39:33]);
                        end
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cnt = 0;
            else
            begin
                stall_cnt++;
                if (stall_cnt >= STALL_LIMIT)
                begin
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    // ---------------- test sequence ----------------

    initial
    begin
        ext_code[CFG_COOKIE]   = COOKIE_TYPE_RST;
        ext_code[CFG_VERSIONS] = VERSIONS_TYPE_RST;
        ext_code[CFG_GROUPS]   = GROUPS_TYPE_RST;
        ext_code[CFG_SHARES]   = SHARES_TYPE_RST;
        clear_scan();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset codes
        hello_buf.push_back(LEGACY_VERSION[15:8]);
        send_buf(1);                                    // message of one byte
        put_hdr(16'hfeff, 0, 0, 2, 0);
        send_buf(3);                                    // bad version
        put_hdr(LEGACY_VERSION, 0, 0, 2, 1);
        put_ext(COOKIE_TYPE_RST, 2);
        put_ext(VERSIONS_TYPE_RST, 0);                  // zero-length extension
        put_ext(GROUPS_TYPE_RST, 1);
        put_ext(16'h1234, 1);                           // not watched
        put_ext(SHARES_TYPE_RST, 3);
        send_buf(0);                                    // ends on a field end
        put_hdr(LEGACY_VERSION, 0, 1, 2, 0);
        send_buf(0);                                    // cookie not empty
        put_hdr(LEGACY_VERSION, 0, 0, 3, 0);
        send_buf(0);                                    // odd suites length
        put_hdr(LEGACY_VERSION, 0, 0, 0, 0);
        send_buf(0);                                    // suites length zero
        put_hdr(LEGACY_VERSION, 0, 0, 2, 0);
        send_buf(34);                                   // ends on last random byte
        put_hdr(LEGACY_VERSION, 0, 0, 2, 2);
        send_buf(39);                                   // cut inside suites
        put_hdr(LEGACY_VERSION, 0, 0, 2, 2);
        send_buf(42);                                   // cut inside compression
        put_hdr(LEGACY_VERSION, 0, 0, 2, 0);
        put_ext(COOKIE_TYPE_RST, 5);
        send_buf(hello_buf.size() - 1);                 // cut inside an extension
        settle();

        // Extreme codes, overlapping registers, no idling on either side
        set_codes(16'hffff, 16'hffff, 16'h0000, 16'h0000);
        no_idle = 1'b1;
        put_hdr(LEGACY_VERSION, 255, 0, 2, 0);
        put_ext(16'hffff, 1);
        put_ext(16'h0000, 0);
        send_buf(0);
        settle();
        no_idle = 1'b0;
        run_random(25);
        settle();

        // Random codes
        set_codes(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        run_random(25);
        settle();

        // Back to the usual codes
        set_codes(COOKIE_TYPE_RST, VERSIONS_TYPE_RST, GROUPS_TYPE_RST, SHARES_TYPE_RST);
        run_random(25);
        settle();

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
